### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk with reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clk edge outside reset.
`define UML_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clk edge, reset included.
`define UML_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/uml_pkg.sv
// ---------------------------------------------------------------------------
// Unique marker locator package
// Sizes, widths and result status codes shared by the locator.
// ---------------------------------------------------------------------------
package uml_pkg;

    localparam int PATTERN_BYTES = 8;
    localparam int OFFSET_BITS   = 32;

    localparam int MARKER_BITS = 64;
    localparam int PAT_BITS    = 8 * PATTERN_BYTES;
    localparam int WIN_BITS    = 8 * (PATTERN_BYTES - 1);
    localparam int OUT_BITS    = 40;

    typedef logic [OFFSET_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        STATUS_UNIQUE = 2'd0,
        STATUS_NONE   = 2'd1,
        STATUS_SECOND = 2'd2
    } status_t;

endpackage

### src/unique_marker_locator_core.sv
// ---------------------------------------------------------------------------
// Unique marker locator core
// Scans a byte stream for a configured marker and reports whether it occurs
// exactly once, with the offset of the first occurrence.
// ---------------------------------------------------------------------------
// Input channel s_*: one file byte per word, tlast on the final byte.
// Output channel m_*: one word per file, sent after its final byte: status in
// tdata[1:0], first match offset in tdata[33:2].
// Configuration: cfg_wr_en loads cfg_wr_data as the marker, first file byte in
// bits 7:0; write only while no file is in flight.
// Throughput: one byte per clock while no result word is stalled; the window compare and
// counter update for a byte are combinational between the input register and the scan state.
// Result: the result word is registered when the final byte leaves the input register.
// Reset clears the marker, the scan state and both channel registers.
// When m_tready is low the result word holds; the input register keeps taking
// bytes until a byte is waiting behind the stalled result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module unique_marker_locator_core
    import uml_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [MARKER_BITS-1:0] cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BITS-1:0]    m_tdata    // [1:0] status, [33:2] match_offset
);

    localparam count_t CNT_MAX   = '1;
    localparam count_t CMP_START = OFFSET_BITS'(PATTERN_BYTES - 1);

    logic [MARKER_BITS-1:0] marker_reg;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;

    logic [WIN_BITS-1:0] window_reg, window_next;
    count_t              byte_count_reg, byte_count_next;
    logic [31:0]         first_offset_reg, first_offset_next;
    logic                match_seen_reg, match_seen_next;
    logic                second_seen_reg, second_seen_next;

    logic                out_valid_reg;
    status_t             out_status_reg, out_status_next;
    logic [31:0]         out_offset_reg, out_offset_next;

    logic                advance;
    logic                proc_en;
    logic [PAT_BITS-1:0] full_win;
    logic                hit;
    count_t              start_off;
    logic [63:0]         start_wide;
    logic [31:0]         start_clamp;

    assign advance  = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign full_win    = {in_byte_reg, window_reg};
    assign hit         = (byte_count_reg >= CMP_START) && (full_win == marker_reg[PAT_BITS-1:0]);
    assign start_off   = byte_count_reg - CMP_START;
    assign start_wide  = 64'(start_off);
    assign start_clamp = (start_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                 : start_wide[31:0];

    always_comb
    begin
        window_next       = full_win[PAT_BITS-1:8];
        byte_count_next   = (byte_count_reg != CNT_MAX) ? byte_count_reg + 1'b1
                                                        : byte_count_reg;
        first_offset_next = first_offset_reg;
        match_seen_next   = match_seen_reg;
        second_seen_next  = second_seen_reg;
        if (hit)
        begin
            if (!match_seen_reg)
            begin
                match_seen_next   = 1'b1;
                first_offset_next = start_clamp;
            end
            else
            begin
                second_seen_next = 1'b1;
            end
        end

        if (second_seen_next)
            out_status_next = STATUS_SECOND;
        else if (match_seen_next)
            out_status_next = STATUS_UNIQUE;
        else
            out_status_next = STATUS_NONE;
        out_offset_next = match_seen_next ? first_offset_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg       <= '0;
            in_valid_reg     <= 1'b0;
            in_byte_reg      <= '0;
            in_last_reg      <= 1'b0;
            window_reg       <= '0;
            byte_count_reg   <= '0;
            first_offset_reg <= '0;
            match_seen_reg   <= 1'b0;
            second_seen_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= STATUS_NONE;
            out_offset_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                marker_reg <= cfg_wr_data;

            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
                in_last_reg  <= s_tlast;
            end
            else if (proc_en)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_en && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (proc_en)
            begin
                if (in_last_reg)
                begin
                    window_reg       <= '0;
                    byte_count_reg   <= '0;
                    first_offset_reg <= '0;
                    match_seen_reg   <= 1'b0;
                    second_seen_reg  <= 1'b0;
                    out_status_reg   <= out_status_next;
                    out_offset_reg   <= out_offset_next;
                end
                else
                begin
                    window_reg       <= window_next;
                    byte_count_reg   <= byte_count_next;
                    first_offset_reg <= first_offset_next;
                    match_seen_reg   <= match_seen_next;
                    second_seen_reg  <= second_seen_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_offset_reg, out_status_reg};

    `UML_ASSERT(a_second_needs_first, second_seen_reg |-> match_seen_reg, "second match without first")
    `UML_ASSERT(a_none_zero_offset, (m_tvalid && out_status_reg == STATUS_NONE) |-> (out_offset_reg == 32'd0), "offset set without match")
    `UML_ASSERT(a_clear_after_last, (proc_en && in_last_reg) |=> (byte_count_reg == '0 && !match_seen_reg), "scan state not cleared")
    `UML_ASSERT(a_result_from_last, $rose(m_tvalid) |-> $past(proc_en && in_last_reg), "result without final byte")

endmodule
